### hw/rtl/vrta_pkg.sv
package vrta_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int QUAT_FRAC_BITS  = 14;

    localparam logic [2:0] REG_QUAT_W   = 3'd0;
    localparam logic [2:0] REG_QUAT_X   = 3'd1;
    localparam logic [2:0] REG_QUAT_Y   = 3'd2;
    localparam logic [2:0] REG_QUAT_Z   = 3'd3;
    localparam logic [2:0] REG_OFFSET_X = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y = 3'd5;
    localparam logic [2:0] REG_OFFSET_Z = 3'd6;

    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_COLLIDER = 2'd1;
    localparam logic [1:0] KIND_BODY     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAT,
        ST_MUL,
        ST_SUM,
        ST_ADD,
        ST_BOX,
        ST_OUT_VERT,
        ST_OUT_COLL,
        ST_OUT_BODY
    } vrta_state_t;

    typedef struct packed {
        logic       load;
        logic       mat;
        logic       mul;
        logic       sum;
        logic       add;
        logic       box;
        logic       show;
        logic [1:0] kind;
        logic       last;
    } vrta_cmd_t;

    typedef struct packed {
        logic lv;
        logic lc;
    } vrta_sts_t;

endpackage

### hw/rtl/vertex_rigid_transform_aabb.sv
// Rigid transform of collider vertices with per-collider and body bounding boxes.
// Input channel (in_valid/in_ready): one vertex item with its collider centroid and
// first/last vertex and collider flags. Output channel (out_valid/out_ready): one
// vertex result, then a collider box after a collider's last vertex, then a body
// box after the last collider; last_of_run marks the final result of an item.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// quaternion and body offset; write only while idle.
// Each accepted item runs through the controller's matrix, multiply, sum, add and
// box steps, then the vertex result and any collider and body boxes are presented
// in turn; a new item is taken only once the last result is taken.
// A stalled receiver holds the result and the block takes no new item.
// Reset gives the identity quaternion, zero offset and zeroed boxes.
module vertex_rigid_transform_aabb
    import vrta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] vert_x,
    input  logic signed [31:0] vert_y,
    input  logic signed [31:0] vert_z,
    input  logic signed [31:0] cent_x,
    input  logic signed [31:0] cent_y,
    input  logic signed [31:0] cent_z,
    input  logic               first_vertex,
    input  logic               last_vertex,
    input  logic               first_collider,
    input  logic               last_collider,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] min_x,
    output logic signed [31:0] max_x,
    output logic signed [31:0] min_y,
    output logic signed [31:0] max_y,
    output logic signed [31:0] min_z,
    output logic signed [31:0] max_z,
    output logic [1:0]         result_kind,
    output logic               last_of_run
);

    vrta_cmd_t cmd;
    vrta_sts_t sts;

    assign cfg_ready   = 1'b1;
    assign result_kind = cmd.kind;
    assign last_of_run = cmd.last & cmd.show;

    vrta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    vrta_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vert_x         (vert_x),
        .vert_y         (vert_y),
        .vert_z         (vert_z),
        .cent_x         (cent_x),
        .cent_y         (cent_y),
        .cent_z         (cent_z),
        .first_vertex   (first_vertex),
        .last_vertex    (last_vertex),
        .first_collider (first_collider),
        .last_collider  (last_collider),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .min_x          (min_x),
        .max_x          (max_x),
        .min_y          (min_y),
        .max_y          (max_y),
        .min_z          (min_z),
        .max_z          (max_z)
    );

endmodule

### hw/rtl/vrta_ctrl.sv
module vrta_ctrl
    import vrta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    input  vrta_sts_t sts,
    output vrta_cmd_t cmd
);

    vrta_state_t state_reg;
    vrta_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAT;
                end
            end
            ST_MAT:
            begin
                cmd.mat    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = ST_BOX;
            end
            ST_BOX:
            begin
                cmd.box    = 1'b1;
                state_next = ST_OUT_VERT;
            end
            ST_OUT_VERT:
            begin
                out_valid = 1'b1;
                cmd.kind  = KIND_VERTEX;
                cmd.last  = !sts.lv;
                if (out_ready)
                begin
                    state_next = sts.lv ? ST_OUT_COLL : ST_IDLE;
                end
            end
            ST_OUT_COLL:
            begin
                out_valid = 1'b1;
                cmd.kind  = KIND_COLLIDER;
                cmd.last  = !sts.lc;
                if (out_ready)
                begin
                    state_next = sts.lc ? ST_OUT_BODY : ST_IDLE;
                end
            end
            ST_OUT_BODY:
            begin
                out_valid = 1'b1;
                cmd.kind  = KIND_BODY;
                cmd.last  = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.show = out_valid;
    end

endmodule

### hw/rtl/vrta_dp.sv
module vrta_dp
    import vrta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  vrta_cmd_t          cmd,
    output vrta_sts_t          sts,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] vert_x,
    input  logic signed [31:0] vert_y,
    input  logic signed [31:0] vert_z,
    input  logic signed [31:0] cent_x,
    input  logic signed [31:0] cent_y,
    input  logic signed [31:0] cent_z,
    input  logic               first_vertex,
    input  logic               last_vertex,
    input  logic               first_collider,
    input  logic               last_collider,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] min_x,
    output logic signed [31:0] max_x,
    output logic signed [31:0] min_y,
    output logic signed [31:0] max_y,
    output logic signed [31:0] min_z,
    output logic signed [31:0] max_z
);

    localparam int QF = QUAT_FRAC_BITS;
    localparam int MW = 2 * QF + 6;
    localparam int RW = MW - QF;
    localparam int PW = RW + 33;
    localparam int SW = PW + 2;

    logic signed [15:0] q_reg [4];
    logic signed [31:0] off_reg [3];
    logic signed [31:0] cent_reg [3];
    logic signed [32:0] d_reg [3];
    logic fv_reg, lv_reg, fc_reg, lc_reg;
    logic signed [RW-1:0] m_reg [9];
    logic signed [PW-1:0] p_reg [9];
    logic signed [SW-1:0] s_reg [3];
    logic signed [31:0] w_reg [3];
    logic signed [31:0] cbox_reg [6];
    logic signed [31:0] bbox_reg [6];

    logic signed [MW-1:0] mf [9];
    logic signed [MW-1:0] one;
    logic signed [31:0] qq [9];
    logic signed [31:0] cb_next [6];

    assign one = MW'(1) <<< (2 * QF);

    always_comb
    begin
        qq[0] = 32'(q_reg[1]) * 32'(q_reg[1]);
        qq[1] = 32'(q_reg[2]) * 32'(q_reg[2]);
        qq[2] = 32'(q_reg[3]) * 32'(q_reg[3]);
        qq[3] = 32'(q_reg[1]) * 32'(q_reg[2]);
        qq[4] = 32'(q_reg[1]) * 32'(q_reg[3]);
        qq[5] = 32'(q_reg[2]) * 32'(q_reg[3]);
        qq[6] = 32'(q_reg[0]) * 32'(q_reg[1]);
        qq[7] = 32'(q_reg[0]) * 32'(q_reg[2]);
        qq[8] = 32'(q_reg[0]) * 32'(q_reg[3]);
        mf[0] = one - (MW'(qq[1]) + MW'(qq[2]) <<< 1);
        mf[1] = (MW'(qq[3]) - MW'(qq[8])) <<< 1;
        mf[2] = (MW'(qq[4]) + MW'(qq[7])) <<< 1;
        mf[3] = (MW'(qq[3]) + MW'(qq[8])) <<< 1;
        mf[4] = one - (MW'(qq[0]) + MW'(qq[2]) <<< 1);
        mf[5] = (MW'(qq[5]) - MW'(qq[6])) <<< 1;
        mf[6] = (MW'(qq[4]) - MW'(qq[7])) <<< 1;
        mf[7] = (MW'(qq[5]) + MW'(qq[6])) <<< 1;
        mf[8] = one - (MW'(qq[0]) + MW'(qq[1]) <<< 1);
    end

    function automatic logic signed [31:0] sat32(input logic signed [SW+1:0] v);
        logic signed [SW+1:0] hi;
        logic signed [SW+1:0] lo;
        hi = (SW+2)'(32'sh7fffffff);
        lo = -(SW+2)'(33'sh080000000);
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg[0] <= 16'sd16384;
            q_reg[1] <= '0;
            q_reg[2] <= '0;
            q_reg[3] <= '0;
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++)
            begin
                cbox_reg[i] <= '0;
                bbox_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_QUAT_W:   q_reg[0]   <= cfg_data[15:0];
                    REG_QUAT_X:   q_reg[1]   <= cfg_data[15:0];
                    REG_QUAT_Y:   q_reg[2]   <= cfg_data[15:0];
                    REG_QUAT_Z:   q_reg[3]   <= cfg_data[15:0];
                    REG_OFFSET_X: off_reg[0] <= cfg_data;
                    REG_OFFSET_Y: off_reg[1] <= cfg_data;
                    REG_OFFSET_Z: off_reg[2] <= cfg_data;
                    default:      ;
                endcase
            end
            if (cmd.box)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    cbox_reg[i] <= cb_next[i];
                end
                if (lv_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (fc_reg || cb_next[2*i] < bbox_reg[2*i])
                            bbox_reg[2*i] <= cb_next[2*i];
                        if (fc_reg || cb_next[2*i+1] > bbox_reg[2*i+1])
                            bbox_reg[2*i+1] <= cb_next[2*i+1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cb_next[2*i]   = cbox_reg[2*i];
            cb_next[2*i+1] = cbox_reg[2*i+1];
            if (fv_reg || w_reg[i] < cbox_reg[2*i])
                cb_next[2*i] = w_reg[i];
            if (fv_reg || w_reg[i] > cbox_reg[2*i+1])
                cb_next[2*i+1] = w_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg[0]    <= 33'(vert_x) - 33'(cent_x);
            d_reg[1]    <= 33'(vert_y) - 33'(cent_y);
            d_reg[2]    <= 33'(vert_z) - 33'(cent_z);
            cent_reg[0] <= cent_x;
            cent_reg[1] <= cent_y;
            cent_reg[2] <= cent_z;
            fv_reg      <= first_vertex;
            lv_reg      <= last_vertex;
            fc_reg      <= first_collider;
            lc_reg      <= last_collider;
        end
        if (cmd.mat)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= RW'(mf[i] >>> QF);
            end
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p_reg[i] <= PW'(m_reg[i]) * PW'(d_reg[i % 3]);
            end
        end
        if (cmd.sum)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s_reg[i] <= SW'(p_reg[3*i]) + SW'(p_reg[3*i+1]) + SW'(p_reg[3*i+2]);
            end
        end
        if (cmd.add)
        begin
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i] <= sat32((SW+2)'(s_reg[i] >>> QF) + (SW+2)'(cent_reg[i])
                                  + (SW+2)'(off_reg[i]));
            end
        end
    end

    assign sts.lv = lv_reg;
    assign sts.lc = lc_reg;

    always_comb
    begin
        out_x = '0;
        out_y = '0;
        out_z = '0;
        min_x = '0;
        max_x = '0;
        min_y = '0;
        max_y = '0;
        min_z = '0;
        max_z = '0;
        case (cmd.kind)
            KIND_VERTEX:
            begin
                out_x = w_reg[0];
                out_y = w_reg[1];
                out_z = w_reg[2];
            end
            KIND_COLLIDER:
            begin
                min_x = cbox_reg[0];
                max_x = cbox_reg[1];
                min_y = cbox_reg[2];
                max_y = cbox_reg[3];
                min_z = cbox_reg[4];
                max_z = cbox_reg[5];
            end
            KIND_BODY:
            begin
                min_x = bbox_reg[0];
                max_x = bbox_reg[1];
                min_y = bbox_reg[2];
                max_y = bbox_reg[3];
                min_z = bbox_reg[4];
                max_z = bbox_reg[5];
            end
            default:
            begin
                out_x = '0;
            end
        endcase
    end

endmodule

### tb/sv/vrta_checker.sv
`timescale 1ns / 1ps

module vrta_checker
    import vrta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] vert_x,
    input  logic signed [31:0] vert_y,
    input  logic signed [31:0] vert_z,
    input  logic signed [31:0] cent_x,
    input  logic signed [31:0] cent_y,
    input  logic signed [31:0] cent_z,
    input  logic               first_vertex,
    input  logic               last_vertex,
    input  logic               first_collider,
    input  logic               last_collider,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    input  logic signed [31:0] min_x,
    input  logic signed [31:0] max_x,
    input  logic signed [31:0] min_y,
    input  logic signed [31:0] max_y,
    input  logic signed [31:0] min_z,
    input  logic signed [31:0] max_z,
    input  logic [1:0]         result_kind,
    input  logic               last_of_run,
    output int                 fail_count,
    output int                 pending,
    output int                 vert_seen,
    output int                 coll_seen,
    output int                 body_seen
);

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [5:0][31:0] box;
        logic [1:0]       kind;
        logic             last;
    } world_res_t;

    world_res_t world_q[$];
    logic signed [63:0] rot_q[4];
    logic signed [63:0] body_off[3];
    logic signed [63:0] coll_bnd[6];
    logic signed [63:0] body_bnd[6];

    function automatic logic signed [63:0] fdiv(input logic signed [63:0] a, input int s);
        return a >>> s;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] a);
        if (a > 64'sd2147483647)
            return 64'sd2147483647;
        if (a < -64'sd2147483648)
            return -64'sd2147483648;
        return a;
    endfunction

    task automatic transform_vertex(input logic signed [31:0] v[3],
                                    input logic signed [31:0] c[3],
                                    input logic fv, input logic lv,
                                    input logic fc, input logic lc);
        logic signed [63:0] one, qw, qx, qy, qz;
        logic signed [63:0] m[3][3];
        logic signed [63:0] d[3];
        logic signed [63:0] w[3];
        logic signed [127:0] acc;
        world_res_t r;
        one = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
        qw = rot_q[0];
        qx = rot_q[1];
        qy = rot_q[2];
        qz = rot_q[3];
        m[0][0] = one - 2 * (qy * qy + qz * qz);
        m[0][1] = 2 * (qx * qy - qw * qz);
        m[0][2] = 2 * (qx * qz + qw * qy);
        m[1][0] = 2 * (qx * qy + qw * qz);
        m[1][1] = one - 2 * (qx * qx + qz * qz);
        m[1][2] = 2 * (qy * qz - qw * qx);
        m[2][0] = 2 * (qx * qz - qw * qy);
        m[2][1] = 2 * (qy * qz + qw * qx);
        m[2][2] = one - 2 * (qx * qx + qy * qy);
        for (int i = 0; i < 3; i++)
            d[i] = 64'(v[i]) - 64'(c[i]);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += 128'(fdiv(m[i][j], QUAT_FRAC_BITS)) * 128'(d[j]);
            acc = acc >>> QUAT_FRAC_BITS;
            w[i] = clamp32(64'(acc) + 64'(c[i]) + body_off[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            if (fv)
            begin
                coll_bnd[2 * i] = w[i];
                coll_bnd[2 * i + 1] = w[i];
            end
            else
            begin
                if (w[i] < coll_bnd[2 * i])
                    coll_bnd[2 * i] = w[i];
                if (w[i] > coll_bnd[2 * i + 1])
                    coll_bnd[2 * i + 1] = w[i];
            end
        end
        r = '0;
        for (int i = 0; i < 3; i++)
            r.pos[i] = w[i][31:0];
        r.kind = KIND_VERTEX;
        r.last = !lv;
        world_q.push_back(r);
        if (lv)
        begin
            r = '0;
            for (int i = 0; i < 6; i++)
                r.box[i] = coll_bnd[i][31:0];
            r.kind = KIND_COLLIDER;
            r.last = !lc;
            world_q.push_back(r);
            for (int i = 0; i < 3; i++)
            begin
                if (fc)
                begin
                    body_bnd[2 * i] = coll_bnd[2 * i];
                    body_bnd[2 * i + 1] = coll_bnd[2 * i + 1];
                end
                else
                begin
                    if (coll_bnd[2 * i] < body_bnd[2 * i])
                        body_bnd[2 * i] = coll_bnd[2 * i];
                    if (coll_bnd[2 * i + 1] > body_bnd[2 * i + 1])
                        body_bnd[2 * i + 1] = coll_bnd[2 * i + 1];
                end
            end
            if (lc)
            begin
                r = '0;
                for (int i = 0; i < 6; i++)
                    r.box[i] = body_bnd[i][31:0];
                r.kind = KIND_BODY;
                r.last = 1'b1;
                world_q.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d actual %0d", name, $signed(exp_v),
                   $signed(act_v));
            fail_count++;
        end
    endtask

    assign pending = world_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] v[3];
        logic signed [31:0] c[3];
        world_res_t e;
        if (!rst_n)
        begin
            rot_q[0] = 16384;
            rot_q[1] = 0;
            rot_q[2] = 0;
            rot_q[3] = 0;
            for (int i = 0; i < 3; i++)
                body_off[i] = 0;
            for (int i = 0; i < 6; i++)
            begin
                coll_bnd[i] = 0;
                body_bnd[i] = 0;
            end
            world_q.delete();
            fail_count = 0;
            vert_seen = 0;
            coll_seen = 0;
            body_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_QUAT_W: rot_q[0] = 64'($signed(cfg_data[15:0]));
                    REG_QUAT_X: rot_q[1] = 64'($signed(cfg_data[15:0]));
                    REG_QUAT_Y: rot_q[2] = 64'($signed(cfg_data[15:0]));
                    REG_QUAT_Z: rot_q[3] = 64'($signed(cfg_data[15:0]));
                    REG_OFFSET_X: body_off[0] = 64'($signed(cfg_data));
                    REG_OFFSET_Y: body_off[1] = 64'($signed(cfg_data));
                    REG_OFFSET_Z: body_off[2] = 64'($signed(cfg_data));
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                v[0] = vert_x; v[1] = vert_y; v[2] = vert_z;
                c[0] = cent_x; c[1] = cent_y; c[2] = cent_z;
                transform_vertex(v, c, first_vertex, last_vertex, first_collider,
                                 last_collider);
            end
            if (out_valid && out_ready)
            begin
                if (world_q.size() == 0)
                begin
                    $error("unexpected result, kind %0d", result_kind);
                    fail_count++;
                end
                else
                begin
                    e = world_q.pop_front();
                    check_field("out_x", e.pos[0], out_x);
                    check_field("out_y", e.pos[1], out_y);
                    check_field("out_z", e.pos[2], out_z);
                    check_field("min_x", e.box[0], min_x);
                    check_field("max_x", e.box[1], max_x);
                    check_field("min_y", e.box[2], min_y);
                    check_field("max_y", e.box[3], max_y);
                    check_field("min_z", e.box[4], min_z);
                    check_field("max_z", e.box[5], max_z);
                    check_field("result_kind", 32'(e.kind), 32'(result_kind));
                    check_field("last_of_run", 32'(e.last), 32'(last_of_run));
                    case (e.kind)
                        KIND_VERTEX: vert_seen++;
                        KIND_COLLIDER: coll_seen++;
                        default: body_seen++;
                    endcase
                end
            end
        end
    end

endmodule

### tb/sv/tb_vertex_rigid_transform_aabb.sv
`timescale 1ns / 1ps

module tb_vertex_rigid_transform_aabb;
    import vrta_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] vert_x, vert_y, vert_z;
    logic signed [31:0] cent_x, cent_y, cent_z;
    logic               first_vertex, last_vertex, first_collider, last_collider;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x, out_y, out_z;
    logic signed [31:0] min_x, max_x, min_y, max_y, min_z, max_z;
    logic [1:0]         result_kind;
    logic               last_of_run;
    int                 fail_count, pending, vert_seen, coll_seen, body_seen;
    int                 cycle_count;
    int                 items_sent;
    bit                 calm;
    bit                 hold_off;

    vertex_rigid_transform_aabb dut (.*);

    vrta_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off
    initial
    begin
        int held;
        out_ready = 1'b0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off && held < 300)
            begin
                held++;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 6);
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'(int'($urandom_range(2000)) - 1000) <<< COORD_FRAC_BITS;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vertex(input logic [31:0] vx, vy, vz, cx, cy, cz,
                               input logic fv, lv, fc, lc);
        @(posedge clk);
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vert_x <= vx; vert_y <= vy; vert_z <= vz;
        cent_x <= cx; cent_y <= cy; cent_z <= cz;
        first_vertex <= fv; last_vertex <= lv;
        first_collider <= fc; last_collider <= lc;
        do
            @(posedge clk);
        while (!in_ready);
        in_valid <= 1'b0;
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_pose(input logic [15:0] qw, qx, qy, qz,
                            input logic [31:0] ox, oy, oz);
        drain();
        write_reg(REG_QUAT_W, {16'h0, qw});
        write_reg(REG_QUAT_X, {16'h0, qx});
        write_reg(REG_QUAT_Y, {16'h0, qy});
        write_reg(REG_QUAT_Z, {16'h0, qz});
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_OFFSET_Z, oz);
    endtask

    task automatic send_body(input int colliders);
        int nv;
        logic [31:0] cx, cy, cz;
        for (int c = 0; c < colliders; c++)
        begin
            nv = $urandom_range(4, 1);
            cx = pick_coord(); cy = pick_coord(); cz = pick_coord();
            for (int k = 0; k < nv; k++)
                send_vertex(pick_coord(), pick_coord(), pick_coord(), cx, cy, cz,
                            k == 0, k == nv - 1, c == 0, c == colliders - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        vert_x = '0; vert_y = '0; vert_z = '0;
        cent_x = '0; cent_y = '0; cent_z = '0;
        first_vertex = 1'b0; last_vertex = 1'b0;
        first_collider = 1'b0; last_collider = 1'b0;
        cycle_count = 0;
        items_sent = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset pose, no first vertex, extremes, two-vertex single-collider body
        send_vertex(32'h7fffffff, 32'h80000000, 32'h0, 32'h80000000, 32'h7fffffff,
                    32'h0, 1'b0, 1'b1, 1'b0, 1'b1);
        send_vertex(32'h00010000, 32'hffff0000, 32'h7fffffff, 32'h0, 32'h0,
                    32'h80000000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_vertex(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b1, 1'b0);
        send_vertex(32'h00030000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                    1'b1, 1'b0, 1'b1, 1'b1);
        send_vertex(32'hfffd0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                    1'b0, 1'b1, 1'b0, 1'b1);
        set_pose(16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 32'h7fffffff, 32'h80000000, 32'h0);
        write_reg(3'd7, 32'hffffffff);
        send_body(2);
        set_pose(16'h0, 16'h4000, 16'h0, 16'h0, 32'h80000000, 32'h7fffffff,
                 32'h00050000);
        send_body(3);
        set_pose(16'h2d41, 16'h0, 16'h0, 16'h2d41, 32'h0, 32'h0, 32'h0);
        send_body(2);

        // fill up while the receiver is held off
        hold_off = 1'b1;
        send_body(3);

        while (items_sent < 340)
        begin
            if ($urandom_range(3) == 0)
                set_pose(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         $urandom, $urandom, $urandom);
            calm = (items_sent > 150 && items_sent < 220);
            if ($urandom_range(9) == 0)
                send_vertex($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                            1'($urandom));
            else
                send_body($urandom_range(4, 1));
        end
        calm = 1'b0;
        drain();
        $display("Sent %0d vertices over several poses; checked %0d vertex, %0d collider",
                 items_sent, vert_seen, coll_seen);
        $display("and %0d body results.", body_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
